// ----- hw/rtl/sfr_pkg.sv -----
`default_nettype none
package sfr_pkg;

	localparam int FRAME_BYTES = 24;
	localparam int NUM_WORDS   = 10;
	localparam int POS_W       = 5;
	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 16;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_TAIL = 2'd1,
		STATUS_BAD_SUM  = 2'd2
	} sfr_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEAD = 2'd0,
		CFG_TAIL = 2'd1
	} sfr_cfg_idx_t;

	typedef struct packed {
		sfr_status_t                      status;
		logic [BYTE_W-1:0]                stop_ind;
		logic [NUM_WORDS-1:0][WORD_W-1:0] words;
	} sfr_result_t;

	typedef struct packed {
		logic        done;
		sfr_result_t result;
	} sfr_frame_evt_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sfr_frame_collect.sv -----
`default_nettype none
module sfr_frame_collect
	import sfr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic [BYTE_W-1:0] head_byte,
	input  wire logic [BYTE_W-1:0] tail_byte,
	output sfr_frame_evt_t         evt
);

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] CHECK_END = POS_W'(FRAME_BYTES - 2);

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] xor_q;
	logic [BYTE_W-1:0] frame_q [FRAME_BYTES-1];

	logic in_frame;
	logic take;
	logic last;

	assign in_frame = (pos_q != '0);
	assign take     = accept && (in_frame || (rx_byte == head_byte));
	assign last     = (pos_q == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			xor_q <= '0;
		end else if (take) begin
			if (last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (!in_frame) begin
				xor_q <= rx_byte;
			end else if (pos_q < CHECK_END) begin
				xor_q <= xor_q ^ rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_q[0] <= rx_byte;
			for (int i = 1; i < FRAME_BYTES - 1; i++) begin
				frame_q[i] <= frame_q[i-1];
			end
		end
	end

	// On the last byte, frame_q[0] holds the check byte and frame_q[22] the head.
	always_comb begin
		evt.done            = take && last;
		evt.result.stop_ind = frame_q[FRAME_BYTES-3];
		for (int k = 0; k < NUM_WORDS; k++) begin
			evt.result.words[k] = {frame_q[FRAME_BYTES-4-2*k], frame_q[FRAME_BYTES-5-2*k]};
		end
		if (rx_byte != tail_byte) begin
			evt.result.status = STATUS_BAD_TAIL;
		end else if (frame_q[0] != xor_q) begin
			evt.result.status = STATUS_BAD_SUM;
		end else begin
			evt.result.status = STATUS_OK;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(FRAME_BYTES))
		else $error("byte position beyond frame length");

	a_done_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		evt.done |=> pos_q == '0)
		else $error("position not back to idle after frame end");

	a_start_on_head: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_frame && rx_byte == head_byte) |=> pos_q == POS_W'(1))
		else $error("head byte did not start a frame");

endmodule
`default_nettype wire

// ----- hw/rtl/sfr_out_reg.sv -----
`default_nettype none
module sfr_out_reg
	import sfr_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sfr_frame_evt_t evt,
	input  wire logic           out_ready,
	output logic                out_valid,
	output logic                room,
	output sfr_result_t         result
);

	logic        valid_q;
	sfr_result_t result_q;

	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (evt.done) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.done) begin
			result_q <= evt.result;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		evt.done |-> room)
		else $error("result loaded over an untaken result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		evt.done |=> valid_q)
		else $error("finished frame not presented");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> valid_q && $stable(result_q))
		else $error("stalled result lost or changed");

endmodule
`default_nettype wire

// ----- hw/rtl/sensor_frame_receiver_unit.sv -----
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    rx_byte
// out       output     out_valid / out_ready  frame_status, stop_ind, 10 raw words
// cfg       input      cfg_we                 cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_ready is high; a frame result appears the cycle after its last byte.
// The output register holds one result, so in_ready drops only while it is full and stalled.
// Reset returns the receiver to idle, waiting for the head byte, with head 123 and tail 125.
// Bytes other than the head byte are dropped while idle.
`default_nettype none
module sensor_frame_receiver_unit
	import sfr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                frame_status,
	output logic [BYTE_W-1:0]         stop_ind,
	output logic [WORD_W-1:0]         vel_x_raw,
	output logic [WORD_W-1:0]         vel_y_raw,
	output logic [WORD_W-1:0]         vel_z_raw,
	output logic [WORD_W-1:0]         accel_x_raw,
	output logic [WORD_W-1:0]         accel_y_raw,
	output logic [WORD_W-1:0]         accel_z_raw,
	output logic [WORD_W-1:0]         gyro_x_raw,
	output logic [WORD_W-1:0]         gyro_y_raw,
	output logic [WORD_W-1:0]         gyro_z_raw,
	output logic [WORD_W-1:0]         battery_mv,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_wdata
);

	logic [BYTE_W-1:0] head_q;
	logic [BYTE_W-1:0] tail_q;
	logic              room;
	sfr_frame_evt_t    evt;
	sfr_result_t       result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= BYTE_W'(123);
			tail_q <= BYTE_W'(125);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEAD: head_q <= cfg_wdata;
				CFG_TAIL: tail_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_ready = room;

	sfr_frame_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_valid && in_ready),
		.rx_byte   (rx_byte),
		.head_byte (head_q),
		.tail_byte (tail_q),
		.evt       (evt)
	);

	sfr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.room      (room),
		.result    (result)
	);

	assign frame_status = result.status;
	assign stop_ind     = result.stop_ind;
	assign vel_x_raw    = result.words[0];
	assign vel_y_raw    = result.words[1];
	assign vel_z_raw    = result.words[2];
	assign accel_x_raw  = result.words[3];
	assign accel_y_raw  = result.words[4];
	assign accel_z_raw  = result.words[5];
	assign gyro_x_raw   = result.words[6];
	assign gyro_y_raw   = result.words[7];
	assign gyro_z_raw   = result.words[8];
	assign battery_mv   = result.words[9];

endmodule
`default_nettype wire
